// File: sv/mexp_pkg.sv
// Package for the modular exponentiation unit.
// Holds the sequencer states, the register indexes and the command struct.
// No dependencies.
package mexp_pkg;

  localparam int EXP_WIDTH   = 32;
  localparam int BASE_WIDTH  = 33;
  localparam int BIT_IDX_W   = 5;
  localparam int CFG_WIDTH   = 32;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b1;

  localparam logic [CFG_WIDTH-1:0] MODULUS_RST  = 32'd2;
  localparam logic [CFG_WIDTH-1:0] EXPONENT_RST = 32'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BASE,
    S_SQR_GO,
    S_SQR,
    S_MUL_GO,
    S_MUL,
    S_FINISH
  } mexp_state_t;

  // Command to the shared multiply/reduce unit.
  typedef struct packed {
    logic start;
    logic raw_mode;   // reduce the raw operand instead of a*b
  } mexp_cmd_t;

endpackage

// File: sv/mexp_modmul.sv
// Shared modular multiply unit: one multiplier feeding a bit-serial
// restoring remainder over the product or a raw operand. Depends on mexp_pkg.
module mexp_modmul #(
  parameter int MOD_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mexp_pkg::mexp_cmd_t              cmd,
  input  logic [MOD_WIDTH-1:0]             op_a,
  input  logic [MOD_WIDTH-1:0]             op_b,
  input  logic [mexp_pkg::BASE_WIDTH-1:0]  op_raw,
  input  logic [MOD_WIDTH-1:0]             modulus,
  output logic                             done,
  output logic [MOD_WIDTH-1:0]             result
);

  localparam int PROD_W = 2 * MOD_WIDTH;
  localparam int DIV_W  = (PROD_W > mexp_pkg::BASE_WIDTH) ? PROD_W : mexp_pkg::BASE_WIDTH;
  localparam int CNT_W  = $clog2(DIV_W + 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIV_W-1:0]     dvd_r, dvd_nxt;
  logic [MOD_WIDTH-1:0] rem_r, rem_nxt;
  logic [PROD_W-1:0]    prod;
  logic [MOD_WIDTH:0]   shifted;
  logic                 ge;

  assign prod    = op_a * op_b;
  assign shifted = {rem_r, dvd_r[DIV_W-1]};
  assign ge      = shifted >= {1'b0, modulus};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (busy_r) begin
      dvd_nxt = {dvd_r[DIV_W-2:0], 1'b0};
      rem_nxt = ge ? MOD_WIDTH'(shifted - {1'b0, modulus}) : shifted[MOD_WIDTH-1:0];
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end else if (cmd.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIV_W);
      rem_nxt  = '0;
      dvd_nxt  = cmd.raw_mode ? DIV_W'(op_raw) : DIV_W'(prod);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done   = done_r;
  assign result = rem_r;

endmodule

// File: sv/modular_exponentiation_unit.sv
// Top level of the modular exponentiation unit: config registers,
// square-and-multiply sequencer and output register. Uses mexp_pkg, mexp_modmul.
//
// Each base transfer yields one result, base^exponent mod modulus with the
// sign of a truncating C remainder. Work is done by one shared unit: a
// MOD_WIDTH x MOD_WIDTH multiply followed by a bit-serial remainder over
// D = max(2*MOD_WIDTH, 33) bits. An item costs one base reduction, then
// 32 squarings plus one multiply per set exponent bit; the hand-off of the
// result is held only while the output register stays full and is not
// drained. Exponent zero or modulus zero skip the shared unit and go
// straight to the finish state.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register while the next base is taken.
module modular_exponentiation_unit #(
  parameter int MOD_WIDTH = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    cfg_we,
  input  logic [mexp_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mexp_pkg::CFG_WIDTH-1:0]          cfg_wdata,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [mexp_pkg::BASE_WIDTH-1:0]  in_base,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [mexp_pkg::BASE_WIDTH-1:0]  out_power_residue
);

  localparam int BW = mexp_pkg::BASE_WIDTH;

  logic [mexp_pkg::CFG_WIDTH-1:0] modulus_r, exponent_r;

  mexp_pkg::mexp_state_t state_r, state_nxt;
  logic [MOD_WIDTH-1:0]           m_r, m_nxt;
  logic [mexp_pkg::EXP_WIDTH-1:0] e_r, e_nxt;
  logic [MOD_WIDTH-1:0]           acc_r, acc_nxt;
  logic [MOD_WIDTH-1:0]           sq_r, sq_nxt;
  logic                           neg_r, neg_nxt;
  logic [mexp_pkg::BIT_IDX_W-1:0] bit_r, bit_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [BW-1:0]                  out_data_r, out_data_nxt;

  mexp_pkg::mexp_cmd_t  cmd;
  logic [MOD_WIDTH-1:0] op_b;
  logic                 mm_done;
  logic [MOD_WIDTH-1:0] mm_result;
  logic [BW-1:0]        in_mag;
  logic [MOD_WIDTH-1:0] in_m;
  logic [BW-1:0]        signed_val;
  logic                 accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= mexp_pkg::MODULUS_RST;
      exponent_r <= mexp_pkg::EXPONENT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        mexp_pkg::REG_MODULUS:  modulus_r  <= cfg_wdata;
        mexp_pkg::REG_EXPONENT: exponent_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == mexp_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign in_mag   = in_base[BW-1] ? (BW'(0) - BW'(in_base)) : BW'(in_base);
  assign in_m     = modulus_r[MOD_WIDTH-1:0];
  assign op_b     = (state_r == mexp_pkg::S_MUL_GO) ? sq_r : acc_r;

  // Sign per truncating remainder: negative base, odd exponent, nonzero magnitude
  assign signed_val = (neg_r && e_r[0] && (acc_r != '0))
                      ? (BW'(0) - BW'(acc_r)) : BW'(acc_r);

  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    e_nxt         = e_r;
    acc_nxt       = acc_r;
    sq_nxt        = sq_r;
    neg_nxt       = neg_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cmd.start     = 1'b0;
    cmd.raw_mode  = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      mexp_pkg::S_IDLE: begin
        if (accept) begin
          m_nxt   = in_m;
          e_nxt   = exponent_r;
          neg_nxt = in_base[BW-1];
          bit_nxt = '1;
          if (exponent_r == '0) begin
            acc_nxt   = MOD_WIDTH'(1);
            state_nxt = mexp_pkg::S_FINISH;
          end else if (in_m == '0) begin
            acc_nxt   = '0;
            state_nxt = mexp_pkg::S_FINISH;
          end else begin
            acc_nxt      = (in_m == MOD_WIDTH'(1)) ? '0 : MOD_WIDTH'(1);
            cmd.start    = 1'b1;
            cmd.raw_mode = 1'b1;
            state_nxt    = mexp_pkg::S_BASE;
          end
        end
      end
      mexp_pkg::S_BASE: begin
        if (mm_done) begin
          sq_nxt    = mm_result;
          state_nxt = mexp_pkg::S_SQR_GO;
        end
      end
      mexp_pkg::S_SQR_GO: begin
        cmd.start = 1'b1;
        state_nxt = mexp_pkg::S_SQR;
      end
      mexp_pkg::S_SQR: begin
        if (mm_done) begin
          acc_nxt = mm_result;
          if (e_r[bit_r]) begin
            state_nxt = mexp_pkg::S_MUL_GO;
          end else if (bit_r == '0) begin
            state_nxt = mexp_pkg::S_FINISH;
          end else begin
            bit_nxt   = bit_r - 1'b1;
            state_nxt = mexp_pkg::S_SQR_GO;
          end
        end
      end
      mexp_pkg::S_MUL_GO: begin
        cmd.start = 1'b1;
        state_nxt = mexp_pkg::S_MUL;
      end
      mexp_pkg::S_MUL: begin
        if (mm_done) begin
          acc_nxt = mm_result;
          if (bit_r == '0) begin
            state_nxt = mexp_pkg::S_FINISH;
          end else begin
            bit_nxt   = bit_r - 1'b1;
            state_nxt = mexp_pkg::S_SQR_GO;
          end
        end
      end
      mexp_pkg::S_FINISH: begin
        // hand off once the output register is free or being drained
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = signed_val;
          state_nxt     = mexp_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = mexp_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mexp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r        <= m_nxt;
    e_r        <= e_nxt;
    acc_r      <= acc_nxt;
    sq_r       <= sq_nxt;
    neg_r      <= neg_nxt;
    bit_r      <= bit_nxt;
    out_data_r <= out_data_nxt;
  end

  mexp_modmul #(
    .MOD_WIDTH(MOD_WIDTH)
  ) u_modmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .op_a    (acc_r),
    .op_b    (op_b),
    .op_raw  (in_mag),
    .modulus (state_r == mexp_pkg::S_IDLE ? in_m : m_r),
    .done    (mm_done),
    .result  (mm_result)
  );

  assign out_valid         = out_valid_r;
  assign out_power_residue = out_data_r;

endmodule
